[design/hsv_to_rgb555_macros.svh]
// Assertion macros for the HSV to RGB555 converter.
// Used by hsv_to_rgb555.sv; the macros expect signals clk and rst in scope.
`ifndef HSV_TO_RGB555_MACROS_SVH
`define HSV_TO_RGB555_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising edge of clk and off during reset.
`define H2R_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsv_to_rgb555 same-cycle check failed");
// Next-cycle implication, sampled on the rising edge of clk and off during reset.
`define H2R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsv_to_rgb555 next-cycle check failed");
`else
`define H2R_ASSERT_IMPL(label, ante, cons)
`define H2R_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/h2r_pkg.sv]
// Package for the HSV to RGB555 converter: transaction types and fixed-point constants.
// No dependencies; imported by hsv_to_rgb555.
`default_nettype none
package h2r_pkg;

  localparam int unsigned HueW   = 15;
  localparam int unsigned FracW  = 13;
  localparam int unsigned LevelW = 5;

  localparam logic [FracW-1:0]  ONE_Q12      = 13'd4096;
  localparam logic [11:0]       SECTOR_UNITS = 12'd3840;
  localparam logic [HueW-1:0]   FULL_TURN    = 15'd23040;
  localparam logic [LevelW-1:0] LEVEL_MAX    = 5'd31;
  // floor(q / 15) == (q * RECIP15) >> RECIP_SHIFT for every q below 2^16.
  localparam logic [15:0]       RECIP15      = 16'd34953;
  localparam int unsigned       RECIP_SHIFT  = 19;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [FracW-1:0] saturation;
    logic [FracW-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [LevelW-1:0]   red_level;
    logic [LevelW-1:0]   green_level;
    logic [LevelW-1:0]   blue_level;
    logic [3*LevelW-1:0] packed_colour;
  } rgb_t;

endpackage
`default_nettype wire

[design/hsv_to_rgb555.sv]
// HSV to RGB555 converter, a seven-stage pipeline.
// Depends on h2r_pkg and on hsv_to_rgb555_macros.svh for assertions.
//
// Usage:
//   A transaction enters when start is high and busy is low; busy is always
//   low, so one HSV triple can enter on every clock. The hue is in 1/64
//   degree, saturation and brightness in Q1.12 (4096 is one, larger values
//   clamp to one). A hue of 360 degrees or more gives grey.
//   Each result appears on rgb for exactly one cycle with done high, in the
//   order of entry. The receiver cannot stall the block and must take
//   every result when done is high.
//   Throughput is one transaction per clock; the latency is set by the seven
//   register stages: sector search, chroma multiply, chroma and sector
//   weight, X multiply, divide by 15 as a reciprocal multiply, channel
//   select with offset, and level scaling.
//   A synchronous reset clears all valid bits; transactions in flight are
//   dropped and no done pulse follows from them.
`default_nettype none
`include "hsv_to_rgb555_macros.svh"
module hsv_to_rgb555 (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  h2r_pkg::hsv_t hsv,
  output logic          done,
  output h2r_pkg::rgb_t rgb
);
  import h2r_pkg::*;

  // Stage 1: clamp and sector search.
  logic             s1_v;
  logic [HueW-1:0]  s1_hue;
  logic [FracW-1:0] s1_sat, s1_val;
  logic [2:0]       s1_sec;
  logic             s1_grey;
  // Stage 2: chroma product and offset within the sector.
  logic             s2_v;
  logic [25:0]      s2_prod;
  logic [FracW-1:0] s2_val;
  logic [11:0]      s2_within;
  logic [2:0]       s2_sec;
  logic             s2_grey;
  // Stage 3: chroma, grey offset, sector weight.
  logic             s3_v;
  logic [FracW-1:0] s3_chroma, s3_offset;
  logic [11:0]      s3_k;
  logic [2:0]       s3_sec;
  logic             s3_grey;
  // Stage 4: chroma times weight.
  logic             s4_v;
  logic [24:0]      s4_p;
  logic [FracW-1:0] s4_chroma, s4_offset;
  logic [2:0]       s4_sec;
  logic             s4_grey;
  // Stage 5: reciprocal product for the divide by 15.
  logic             s5_v;
  logic [31:0]      s5_qm;
  logic [FracW-1:0] s5_chroma, s5_offset;
  logic [2:0]       s5_sec;
  logic             s5_grey;
  // Stage 6: channel values including the offset.
  logic             s6_v;
  logic [FracW-1:0] s6_r, s6_g, s6_b;
  logic             s6_grey;

  logic [2:0]       sec_next;
  logic             grey_next;
  logic [HueW-1:0]  sec_base;
  logic [FracW-1:0] x5;
  logic [FracW-1:0] r_next, g_next, b_next;
  logic [LevelW-1:0] red_next, green_next, blue_next;

  assign busy = 1'b0;

  always_comb begin
    grey_next = 1'b0;
    priority if (hsv.hue < 15'd3840)  sec_next = 3'd0;
    else if (hsv.hue < 15'd7680)      sec_next = 3'd1;
    else if (hsv.hue < 15'd11520)     sec_next = 3'd2;
    else if (hsv.hue < 15'd15360)     sec_next = 3'd3;
    else if (hsv.hue < 15'd19200)     sec_next = 3'd4;
    else if (hsv.hue < FULL_TURN)     sec_next = 3'd5;
    else begin
      sec_next  = 3'd0;
      grey_next = 1'b1;
    end
  end

  always_comb begin
    unique case (s1_sec)
      3'd0:    sec_base = 15'd0;
      3'd1:    sec_base = 15'd3840;
      3'd2:    sec_base = 15'd7680;
      3'd3:    sec_base = 15'd11520;
      3'd4:    sec_base = 15'd15360;
      default: sec_base = 15'd19200;
    endcase
  end

  assign x5 = s5_qm[31:RECIP_SHIFT];

  always_comb begin
    r_next = s5_offset;
    g_next = s5_offset;
    b_next = s5_offset;
    if (!s5_grey) begin
      unique case (s5_sec)
        3'd0: begin r_next = s5_offset + s5_chroma; g_next = s5_offset + x5; end
        3'd1: begin r_next = s5_offset + x5; g_next = s5_offset + s5_chroma; end
        3'd2: begin g_next = s5_offset + s5_chroma; b_next = s5_offset + x5; end
        3'd3: begin g_next = s5_offset + x5; b_next = s5_offset + s5_chroma; end
        3'd4: begin r_next = s5_offset + x5; b_next = s5_offset + s5_chroma; end
        default: begin r_next = s5_offset + s5_chroma; b_next = s5_offset + x5; end
      endcase
    end
  end

  function automatic logic [LevelW-1:0] to_level(input logic [FracW-1:0] ch);
    logic [17:0] scaled;
    scaled = {ch, 5'b0} - {5'b0, ch};
    return (scaled[17:12] > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : scaled[16:12];
  endfunction

  assign red_next   = to_level(s6_r);
  assign green_next = to_level(s6_g);
  assign blue_next  = to_level(s6_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      done <= 1'b0;
    end else begin
      s1_v <= start && !busy;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      done <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_hue  <= hsv.hue;
    s1_sat  <= (hsv.saturation > ONE_Q12) ? ONE_Q12 : hsv.saturation;
    s1_val  <= (hsv.brightness > ONE_Q12) ? ONE_Q12 : hsv.brightness;
    s1_sec  <= sec_next;
    s1_grey <= grey_next;

    s2_prod   <= s1_val * s1_sat;
    s2_val    <= s1_val;
    s2_within <= 12'(s1_hue - sec_base);
    s2_sec    <= s1_sec;
    s2_grey   <= s1_grey;

    s3_chroma <= s2_prod[24:12];
    s3_offset <= s2_val - s2_prod[24:12];
    s3_k      <= s2_sec[0] ? (SECTOR_UNITS - s2_within) : s2_within;
    s3_sec    <= s2_sec;
    s3_grey   <= s2_grey;

    s4_p      <= s3_chroma * s3_k;
    s4_chroma <= s3_chroma;
    s4_offset <= s3_offset;
    s4_sec    <= s3_sec;
    s4_grey   <= s3_grey;

    // Divide by 3840 as a shift by 8 and a divide by 15.
    s5_qm     <= s4_p[23:8] * RECIP15;
    s5_chroma <= s4_chroma;
    s5_offset <= s4_offset;
    s5_sec    <= s4_sec;
    s5_grey   <= s4_grey;

    s6_r    <= r_next;
    s6_g    <= g_next;
    s6_b    <= b_next;
    s6_grey <= s5_grey;

    rgb.red_level     <= red_next;
    rgb.green_level   <= green_next;
    rgb.blue_level    <= blue_next;
    rgb.packed_colour <= {blue_next, green_next, red_next};
  end

  `H2R_ASSERT_IMPL(a_packed_matches, done, rgb.packed_colour == {rgb.blue_level, rgb.green_level, rgb.red_level})
  `H2R_ASSERT_IMPL(a_channels_in_range, s6_v, (s6_r <= ONE_Q12) && (s6_g <= ONE_Q12) && (s6_b <= ONE_Q12))
  `H2R_ASSERT_IMPL(a_grey_equal, s6_v && s6_grey, (s6_r == s6_g) && (s6_g == s6_b))
  `H2R_ASSERT_NEXT(a_offset_sum, s2_v, (s3_offset + s3_chroma) == $past(s2_val))
  `H2R_ASSERT_NEXT(a_result_follows, s6_v, done)

endmodule
`default_nettype wire
